@@ sv/alternating_bit_sender_core_defines.svh @@
// assertion macros for the alternating bit sender core
`ifndef ALTERNATING_BIT_SENDER_CORE_DEFINES_SVH
`define ALTERNATING_BIT_SENDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ABS_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("abs assertion failed");
`define ABS_ASSERT_NXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("abs assertion failed");
`else
`define ABS_ASSERT_IMP(name, clk_s, rstn_s, ante, cons)
`define ABS_ASSERT_NXT(name, clk_s, rstn_s, ante, cons)
`endif

`endif

@@ sv/abs_pkg.sv @@
// shared types, constants and checksum helpers of the alternating bit sender
`timescale 1ns / 1ps

package abs_pkg;

	localparam int PAYLOAD_WORDS = 10;
	localparam int IDX_W         = $clog2(PAYLOAD_WORDS + 1);
	localparam int ADDR_W        = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
	localparam int WORD_W        = 16;
	localparam int FIELD_W       = 20;

	localparam logic [WORD_W-1:0] ONES16        = 16'hFFFF;
	localparam logic [WORD_W-1:0] TIMEOUT_RESET = 16'd20;

	typedef enum logic [1:0] {
		REQ_MSG_WORD = 2'd0,
		REQ_PKT_HDR  = 2'd1,
		REQ_PKT_WORD = 2'd2,
		REQ_TICK     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		OUT_HDR     = 2'd0,
		OUT_WORD    = 2'd1,
		OUT_CONFIRM = 2'd2
	} out_kind_t;

	typedef struct packed {
		req_type_t            req_type;
		logic [WORD_W-1:0]    data_word;
		logic                 word_last;
		logic [FIELD_W-1:0]   pkt_seq;
		logic [FIELD_W-1:0]   pkt_ack;
		logic [WORD_W-1:0]    pkt_checksum;
	} req_t;

	typedef struct packed {
		out_kind_t            out_kind;
		logic                 out_seq;
		logic                 out_ack;
		logic [WORD_W-1:0]    out_checksum;
		logic [WORD_W-1:0]    out_word;
		logic                 out_last;
	} res_t;

	// ones' complement add with end-around carry
	function automatic logic [WORD_W-1:0] fold_add16(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + WORD_W'(s[WORD_W]);
	endfunction

	// folded sum of the two wide header fields
	function automatic logic [WORD_W-1:0] fold_fields(input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b);
		logic [FIELD_W:0] s;
		logic [WORD_W:0]  t;
		s = {1'b0, a} + {1'b0, b};
		t = {1'b0, s[WORD_W-1:0]} + (WORD_W + 1)'(s[FIELD_W:WORD_W]);
		return t[WORD_W-1:0] + WORD_W'(t[WORD_W]);
	endfunction

endpackage

@@ sv/abs_req_if.sv @@
// input channel: message words, incoming packet words and ticks
`timescale 1ns / 1ps

interface abs_req_if import abs_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/abs_res_if.sv @@
// output channel: packet headers, payload words and confirmations
`timescale 1ns / 1ps

interface abs_res_if import abs_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/alternating_bit_sender_core.sv @@
// Stop-and-wait sender with a one-bit sequence number. Message words, incoming packet
// words and timer ticks share the req channel; req transactions that cause no result
// are taken back to back while no burst runs. A transaction that sends a packet (last
// message word, valid NACK, timer expiry) holds off req while the header and then the
// payload words are issued, the payload read out of the packet memory one word per
// cycle while res does not stall, through its single read port; a valid ACK likewise
// holds off req until its confirmation enters the read stage. Back pressure on res
// lengthens these bursts. The payload words sit in a one-port-write, one-port-read
// synchronous memory; slots beyond the length of a short message go out as zero.
// timeout_ticks (held in timeout_q) resets to 20 and is written through cfg_we / cfg_wdata;
// the user must write it only while the block is idle, the block does not enforce this.
`timescale 1ns / 1ps
`include "alternating_bit_sender_core_defines.svh"

module alternating_bit_sender_core import abs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	abs_req_if.sink           req,
	abs_res_if.source         res
);

	typedef enum logic [1:0] {BS_IDLE, BS_HDR, BS_PAY, BS_CONF} burst_state_t;

	// sender state
	logic [WORD_W-1:0]  timeout_q;
	logic               awaiting_q;
	logic               seq_bit_q;
	logic [WORD_W-1:0]  pkt_sum_q;
	logic [WORD_W-1:0]  msg_sum_q;
	logic [IDX_W-1:0]   msg_idx_q;
	logic [IDX_W-1:0]   pkt_len_q;
	logic               drop_q;
	logic [WORD_W-1:0]  timer_cnt_q;
	logic               timer_run_q;
	logic [FIELD_W-1:0] rx_ack_q;
	logic [WORD_W-1:0]  rx_chk_q;
	logic [WORD_W-1:0]  rx_sum_q;

	// packet memory
	logic [WORD_W-1:0]  pkt_mem [PAYLOAD_WORDS];

	// burst sequencer, read stage and output register
	burst_state_t       burst_state_q;
	logic [ADDR_W-1:0]  slot_q;
	logic               valid_s1;
	out_kind_t          kind_s1;
	logic               seq_s1;
	logic [WORD_W-1:0]  chk_s1;
	logic               last_s1;
	logic               live_s1;
	logic [WORD_W-1:0]  rdata_s1;
	logic               out_valid_q;
	res_t               out_q;

	req_t               p;
	logic               accept;
	logic               s1_adv;
	logic               issue;
	logic               last_slot;
	logic               burst_done;
	logic               rd_en;
	logic               wr_en;
	logic               msg_start;
	logic               msg_drop;
	logic               msg_store;
	logic [WORD_W-1:0]  msg_base;
	logic [WORD_W-1:0]  msg_sum_nx;
	logic [IDX_W-1:0]   msg_idx_nx;
	logic [WORD_W-1:0]  rx_sum_nx;
	logic               rx_done;
	logic               timer_fire;
	logic               do_send;
	logic               do_conf;
	res_t               out_nx;

	assign p          = req.payload;
	assign accept     = req.valid && req.ready;
	assign s1_adv     = valid_s1 && (!out_valid_q || res.ready);
	assign issue      = (burst_state_q != BS_IDLE) && (!valid_s1 || s1_adv);
	assign last_slot  = (slot_q == ADDR_W'(PAYLOAD_WORDS - 1));
	assign burst_done = issue && ((burst_state_q == BS_CONF) ||
		((burst_state_q == BS_PAY) && last_slot));
	assign rd_en      = issue && (burst_state_q == BS_PAY);

	assign req.ready   = (burst_state_q == BS_IDLE) || burst_done;
	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

	always_comb begin
		msg_start  = (msg_idx_q == '0) && !drop_q;
		msg_drop   = drop_q || (msg_start && awaiting_q);
		msg_store  = !msg_drop && (msg_idx_q < IDX_W'(PAYLOAD_WORDS));
		msg_base   = msg_start ? WORD_W'(seq_bit_q) : msg_sum_q;
		msg_sum_nx = msg_store ? fold_add16(msg_base, p.data_word) : msg_base;
		msg_idx_nx = msg_store ? msg_idx_q + IDX_W'(1) : msg_idx_q;
		rx_sum_nx  = fold_add16(rx_sum_q, p.data_word);
		rx_done    = p.word_last && awaiting_q &&
			(({1'b0, rx_sum_nx} + {1'b0, rx_chk_q}) == {1'b0, ONES16});
		timer_fire = timer_run_q && (timer_cnt_q <= WORD_W'(1));
		do_send    = 1'b0;
		do_conf    = 1'b0;
		wr_en      = 1'b0;
		if (accept) begin
			unique case (p.req_type)
				REQ_MSG_WORD: begin
					do_send = !msg_drop && p.word_last;
					wr_en   = msg_store;
				end
				REQ_PKT_WORD: begin
					do_conf = rx_done && (rx_ack_q == FIELD_W'(1));
					do_send = rx_done && (rx_ack_q == '0);
				end
				REQ_TICK: begin
					do_send = timer_fire;
				end
				REQ_PKT_HDR: begin
				end
			endcase
		end
	end

	always_comb begin
		out_nx.out_kind     = kind_s1;
		out_nx.out_seq      = seq_s1;
		out_nx.out_ack      = 1'b0;
		out_nx.out_checksum = chk_s1;
		out_nx.out_word     = live_s1 ? rdata_s1 : '0;
		out_nx.out_last     = last_s1;
	end

	// sender state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			awaiting_q  <= 1'b0;
			seq_bit_q   <= 1'b0;
			pkt_sum_q   <= '0;
			msg_sum_q   <= '0;
			msg_idx_q   <= '0;
			pkt_len_q   <= '0;
			drop_q      <= 1'b0;
			timer_cnt_q <= '0;
			timer_run_q <= 1'b0;
			rx_ack_q    <= '0;
			rx_chk_q    <= '0;
			rx_sum_q    <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (accept) begin
				unique case (p.req_type)
					REQ_MSG_WORD: begin
						if (msg_drop) begin
							drop_q <= !p.word_last;
						end else begin
							msg_sum_q <= msg_sum_nx;
							if (p.word_last) begin
								msg_idx_q   <= '0;
								pkt_len_q   <= msg_idx_nx;
								pkt_sum_q   <= msg_sum_nx;
								awaiting_q  <= 1'b1;
								timer_cnt_q <= timeout_q;
								timer_run_q <= 1'b1;
							end else begin
								msg_idx_q <= msg_idx_nx;
							end
						end
					end
					REQ_PKT_HDR: begin
						rx_ack_q <= p.pkt_ack;
						rx_chk_q <= p.pkt_checksum;
						rx_sum_q <= fold_fields(p.pkt_ack, p.pkt_seq);
					end
					REQ_PKT_WORD: begin
						rx_sum_q <= rx_sum_nx;
						if (do_conf) begin
							awaiting_q  <= 1'b0;
							seq_bit_q   <= !seq_bit_q;
							timer_run_q <= 1'b0;
							timer_cnt_q <= '0;
						end else if (do_send) begin
							timer_cnt_q <= timeout_q;
							timer_run_q <= 1'b1;
						end
					end
					REQ_TICK: begin
						if (timer_run_q) begin
							if (timer_fire) begin
								timer_cnt_q <= timeout_q;
							end else begin
								timer_cnt_q <= timer_cnt_q - WORD_W'(1);
							end
						end
					end
				endcase
			end
		end
	end

	// packet memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pkt_mem[msg_idx_q[ADDR_W-1:0]] <= p.data_word;
		end
		if (rd_en) begin
			rdata_s1 <= pkt_mem[slot_q];
		end
	end

	// burst sequencer, read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_state_q <= BS_IDLE;
			slot_q        <= '0;
			valid_s1      <= 1'b0;
			kind_s1       <= OUT_HDR;
			seq_s1        <= 1'b0;
			chk_s1        <= '0;
			last_s1       <= 1'b0;
			live_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
				unique case (burst_state_q)
					BS_HDR: begin
						kind_s1 <= OUT_HDR;
						seq_s1  <= seq_bit_q;
						chk_s1  <= ~pkt_sum_q;
						last_s1 <= 1'b0;
						live_s1 <= 1'b0;
						slot_q  <= '0;
					end
					BS_PAY: begin
						kind_s1 <= OUT_WORD;
						seq_s1  <= 1'b0;
						chk_s1  <= '0;
						last_s1 <= last_slot;
						live_s1 <= (IDX_W'(slot_q) < pkt_len_q);
						slot_q  <= slot_q + ADDR_W'(1);
					end
					BS_CONF: begin
						kind_s1 <= OUT_CONFIRM;
						seq_s1  <= 1'b0;
						chk_s1  <= '0;
						last_s1 <= 1'b1;
						live_s1 <= 1'b0;
					end
					BS_IDLE: begin
					end
				endcase
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (do_send) begin
				burst_state_q <= BS_HDR;
			end else if (do_conf) begin
				burst_state_q <= BS_CONF;
			end else if (burst_done) begin
				burst_state_q <= BS_IDLE;
			end else if (issue && (burst_state_q == BS_HDR)) begin
				burst_state_q <= BS_PAY;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				out_q       <= out_nx;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ABS_ASSERT_IMP(a_idle_no_timer, clk, arst_n, !awaiting_q, !timer_run_q)
	`ABS_ASSERT_IMP(a_rd_wr_excl, clk, arst_n, rd_en, !wr_en)
	`ABS_ASSERT_IMP(a_msg_idx_range, clk, arst_n, 1'b1, msg_idx_q <= IDX_W'(PAYLOAD_WORDS))
	`ABS_ASSERT_IMP(a_len_set, clk, arst_n, awaiting_q, pkt_len_q != '0)
	`ABS_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv, valid_s1 && $stable(last_s1) && $stable(kind_s1))

endmodule

@@ bench/tb_alternating_bit_sender_core.sv @@
// self-checking testbench for the alternating bit sender core with a predicting scoreboard
`timescale 1ns / 1ps

module tb_alternating_bit_sender_core;
	import abs_pkg::*;

	class sender_scoreboard;
		logic [15:0] timeout;
		bit          awaiting;
		bit          seq_bit;
		bit          dropping;
		bit          timer_on;
		logic [15:0] pbuf [PAYLOAD_WORDS];
		logic [15:0] packet_sum;
		logic [15:0] timer_left;
		logic [15:0] rx_chk;
		logic [15:0] rx_sum;
		logic [19:0] rx_ack;
		int unsigned msg_idx;
		res_t        expected_out [$];
		int          errors;

		function new();
			timeout    = TIMEOUT_RESET;
			awaiting   = 0;
			seq_bit    = 0;
			dropping   = 0;
			timer_on   = 0;
			packet_sum = '0;
			timer_left = '0;
			rx_chk     = '0;
			rx_sum     = '0;
			rx_ack     = '0;
			msg_idx    = 0;
			errors     = 0;
			foreach (pbuf[i]) pbuf[i] = '0;
		endfunction

		static function logic [15:0] fold32(input logic [31:0] s);
			while (s[31:16] != 16'd0)
				s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
			return s[15:0];
		endfunction

		function void emit(input out_kind_t k, input logic sq, input logic [15:0] chk,
				input logic [15:0] w, input logic lst);
			res_t r;
			r.out_kind     = k;
			r.out_seq      = sq;
			r.out_ack      = 1'b0;
			r.out_checksum = chk;
			r.out_word     = w;
			r.out_last     = lst;
			expected_out.push_back(r);
		endfunction

		function void restart_timer();
			timer_left = timeout;
			timer_on   = 1;
		endfunction

		function void queue_packet();
			emit(OUT_HDR, seq_bit, ~packet_sum, 16'd0, 1'b0);
			for (int i = 0; i < PAYLOAD_WORDS; i++)
				emit(OUT_WORD, 1'b0, 16'd0, pbuf[i], i == PAYLOAD_WORDS - 1);
		endfunction

		// returns 0 when the transaction is ignored outright
		function bit note_request(input req_t q);
			logic [31:0] s;
			case (q.req_type)
				REQ_MSG_WORD: begin
					if (msg_idx == 0 && !dropping) begin
						if (awaiting)
							dropping = 1;
						else
							foreach (pbuf[i]) pbuf[i] = '0;
					end
					if (dropping) begin
						if (q.word_last)
							dropping = 0;
						return 1;
					end
					if (msg_idx < PAYLOAD_WORDS) begin
						pbuf[msg_idx] = q.data_word;
						msg_idx++;
					end
					if (!q.word_last)
						return 1;
					msg_idx = 0;
					s = {31'd0, seq_bit};
					foreach (pbuf[i]) s = s + {16'd0, pbuf[i]};
					packet_sum = fold32(s);
					awaiting = 1;
					restart_timer();
					queue_packet();
					return 1;
				end
				REQ_PKT_HDR: begin
					rx_ack = q.pkt_ack;
					rx_chk = q.pkt_checksum;
					rx_sum = fold32({12'd0, q.pkt_ack} + {12'd0, q.pkt_seq});
					return 1;
				end
				REQ_PKT_WORD: begin
					rx_sum = fold32({16'd0, rx_sum} + {16'd0, q.data_word});
					if (!q.word_last || !awaiting)
						return 1;
					if ({16'd0, rx_sum} + {16'd0, rx_chk} != 32'h0000FFFF)
						return 1;
					if (rx_ack == 20'd1) begin
						awaiting   = 0;
						seq_bit    = ~seq_bit;
						timer_on   = 0;
						timer_left = '0;
						emit(OUT_CONFIRM, 1'b0, 16'd0, 16'd0, 1'b1);
					end else if (rx_ack == 20'd0) begin
						restart_timer();
						queue_packet();
					end
					return 1;
				end
				default: begin
					if (!timer_on)
						return 0;
					if (timer_left <= 16'd1) begin
						restart_timer();
						queue_packet();
					end else begin
						timer_left--;
					end
					return 1;
				end
			endcase
		endfunction

		function void cmp(input string f, input logic [15:0] e, input logic [15:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, f, e, a);
			end
		endfunction

		function void check_result(input res_t a);
			res_t e;
			if (expected_out.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, a);
				return;
			end
			e = expected_out.pop_front();
			cmp("out_kind", 16'(e.out_kind), 16'(a.out_kind));
			cmp("out_seq", 16'(e.out_seq), 16'(a.out_seq));
			cmp("out_ack", 16'(e.out_ack), 16'(a.out_ack));
			cmp("out_checksum", e.out_checksum, a.out_checksum);
			cmp("out_word", e.out_word, a.out_word);
			cmp("out_last", 16'(e.out_last), 16'(a.out_last));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [WORD_W-1:0] cfg_wdata;

	abs_req_if req_ch ();
	abs_res_if res_ch ();

	alternating_bit_sender_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	sender_scoreboard sb;
	int snd_idle;
	int rcv_idle;
	int counted;
	int hold_asks;
	int hold_seen;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver side, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.payload);
	end

	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t rand_req(input req_type_t t);
		req_t r;
		r.req_type     = t;
		r.data_word    = 16'($urandom);
		r.word_last    = 1'($urandom);
		r.pkt_seq      = 20'($urandom);
		r.pkt_ack      = 20'($urandom);
		r.pkt_checksum = 16'($urandom);
		return r;
	endfunction

	task automatic push_req(input req_t r);
		if ($urandom_range(99) < snd_idle) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		if (sb.note_request(r))
			counted++;
	endtask

	task automatic push_msg_word(input logic [15:0] w, input logic lst);
		req_t r;
		r = rand_req(REQ_MSG_WORD);
		r.data_word = w;
		r.word_last = lst;
		push_req(r);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			push_msg_word(rand_word(), i == len - 1);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) push_req(rand_req(REQ_TICK));
	endtask

	// fixed < 0 picks random payload words
	task automatic send_link_packet(input logic [19:0] ack, input logic [19:0] seq,
			input int n, input bit corrupt, input int fixed);
		req_t        r;
		logic [15:0] sum;
		logic [15:0] w [$];
		int          i;
		sum = sender_scoreboard::fold32({12'd0, ack} + {12'd0, seq});
		for (i = 0; i < n; i++) begin
			w.push_back(fixed < 0 ? rand_word() : 16'(fixed));
			sum = sender_scoreboard::fold32({16'd0, sum} + {16'd0, w[i]});
		end
		r = rand_req(REQ_PKT_HDR);
		r.pkt_ack      = ack;
		r.pkt_seq      = seq;
		r.pkt_checksum = ~sum;
		if (corrupt)
			r.pkt_checksum = r.pkt_checksum ^ 16'($urandom_range(16'hFFFF, 1));
		push_req(r);
		for (i = 0; i < n; i++) begin
			r = rand_req(REQ_PKT_WORD);
			r.data_word = w[i];
			r.word_last = (i == n - 1);
			push_req(r);
		end
	endtask

	task automatic write_timeout(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.timeout = v;
	endtask

	task automatic drain();
		int n;
		req_ch.valid <= 1'b0;
		n = 0;
		while (sb.expected_out.size() != 0 && n < 50000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
	endtask

	function automatic int msg_len();
		int p;
		p = $urandom_range(99);
		if (p < 70)
			return $urandom_range(9, 1);
		if (p < 85)
			return PAYLOAD_WORDS;
		return $urandom_range(PAYLOAD_WORDS + 4, PAYLOAD_WORDS + 1);
	endfunction

	task automatic one_sequence();
		int          pick;
		logic [19:0] seq;
		pick = $urandom_range(99);
		seq  = 20'($urandom);
		if (!sb.awaiting) begin
			if (pick < 55)
				send_message(msg_len());
			else if (pick < 65)
				send_link_packet(20'd1, seq, $urandom_range(4, 1), 0, -1);
			else if (pick < 75)
				send_link_packet(20'd0, seq, $urandom_range(4, 1), 0, -1);
			else if (pick < 85)
				send_ticks($urandom_range(4, 1));
			else
				push_req(rand_req(req_type_t'($urandom_range(3))));
		end else begin
			if (pick < 20)
				send_link_packet(20'd1, seq, $urandom_range(4, 1), 0, -1);
			else if (pick < 35)
				send_link_packet(20'd0, seq, $urandom_range(4, 1), 0, -1);
			else if (pick < 45)
				send_link_packet(20'($urandom_range(1)), seq, $urandom_range(4, 1), 1, -1);
			else if (pick < 50)
				send_link_packet(20'($urandom_range(20'hFFFFF, 2)), seq,
					$urandom_range(4, 1), 0, -1);
			else if (pick < 75)
				send_ticks(($urandom_range(9) == 0) ? $urandom_range(25, 15)
					: $urandom_range(6, 1));
			else if (pick < 88)
				send_message(msg_len());
			else
				push_req(rand_req(req_type_t'($urandom_range(3))));
		end
	endtask

	initial begin
		logic [15:0] touts [6];
		req_t        r;
		sb = new();
		hold_asks = 0;
		snd_idle  = 0;
		rcv_idle  = 0;
		counted   = 0;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: idle tick, idle ack, short message, drop while waiting, nack, odd ack,
		// corrupt ack, stray payload word, real ack, long message
		push_req(rand_req(REQ_TICK));
		send_link_packet(20'd1, 20'd0, 1, 0, 0);
		push_msg_word(16'hFFFF, 1'b1);
		push_msg_word(16'h1234, 1'b0);
		push_msg_word(16'h0000, 1'b1);
		send_link_packet(20'd0, 20'hFFFFF, 1, 0, 16'hFFFF);
		send_link_packet(20'hFFFFF, 20'h12345, 1, 0, -1);
		send_link_packet(20'd1, 20'd0, 1, 1, -1);
		r = rand_req(REQ_PKT_WORD);
		r.word_last = 1'b1;
		push_req(r);
		send_link_packet(20'd1, 20'd0, 1, 0, 0);
		send_message(PAYLOAD_WORDS + 1);
		drain();

		touts[0] = 16'd1;
		touts[1] = 16'hFFFF;
		touts[2] = 16'd0;
		touts[3] = 16'($urandom_range(6, 2));
		touts[4] = 16'd3;
		touts[5] = 16'($urandom_range(40, 1));
		for (int ph = 0; ph < 6; ph++) begin
			snd_idle = (ph < 2) ? 30 : (ph < 4) ? 46 : 0;
			rcv_idle = (ph < 2) ? 46 : (ph < 4) ? 30 : 0;
			write_timeout(touts[ph]);
			if (ph == 4)
				hold_asks++;
			counted = 0;
			while (counted < 70)
				one_sequence();
			drain();
		end

		if (sb.expected_out.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.expected_out.size());
		if (sb.errors == 0 && sb.expected_out.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
